FILE: rtl/mbrf_pkg.sv
// Shared types, codes and CRC helpers for the Modbus RTU request framer.
package mbrf_pkg;

  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_HEADER  = 2'd2;
  localparam logic [1:0] CMD_PAYLOAD = 2'd3;

  localparam logic [7:0] FC_READ_COILS     = 8'h01;
  localparam logic [7:0] FC_READ_INPUTS    = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
  localparam logic [7:0] FC_READ_INPUT_REG = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
  localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int JOB_BYTES  = 8;
  localparam int JOB_IDX_W  = $clog2(JOB_BYTES);
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_IDX_W-1:0]      nbytes;
    logic                      restart;
    logic                      close;
  } job_t;

  function automatic logic [15:0] ref_base(input logic [7:0] fc);
    logic [15:0] base;
    case (fc)
      FC_READ_COILS:     base = 16'd1;
      FC_READ_INPUTS:    base = 16'd10001;
      FC_READ_HOLDING:   base = 16'd40001;
      FC_READ_INPUT_REG: base = 16'd30001;
      default:           base = 16'd0;
    endcase
    return base;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/mbrf_front.sv
// Front end: classifies request items and builds byte jobs for the serialiser.
module mbrf_front
  import mbrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_slave_address,
  input  logic [7:0] in_function_code,
  input  logic [15:0] in_register_address,
  input  logic [7:0] in_count,
  input  logic [7:0] in_value,
  input  logic       in_last_item,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic        coil_mode_r;
  logic        coil_mode_nxt;
  logic [15:0] rd_addr;
  logic [8:0]  coil_sum;
  logic [7:0]  byte_cnt;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    rd_addr  = in_register_address - ref_base(in_function_code);
    coil_sum = {1'b0, in_count} + 9'd7;
    byte_cnt = (in_function_code == FC_WRITE_COILS) ? {2'b00, coil_sum[8:3]}
                                                    : {in_count[6:0], 1'b0};
    coil_mode_nxt = coil_mode_r;
    q_job         = '0;
    q_job.bytes[0] = in_slave_address;
    q_job.bytes[1] = in_function_code;
    case (in_cmd)
      CMD_READ: begin
        q_job.bytes[2] = rd_addr[15:8];
        q_job.bytes[3] = rd_addr[7:0];
        q_job.bytes[5] = in_count;
        q_job.nbytes   = JOB_IDX_W'(6);
        q_job.restart  = 1'b1;
        q_job.close    = 1'b1;
      end
      CMD_WRITE: begin
        q_job.bytes[2] = in_register_address[15:8];
        q_job.bytes[3] = in_register_address[7:0];
        if (in_function_code == FC_WRITE_COIL) begin
          q_job.bytes[4] = (in_value != 8'h00) ? 8'hFF : 8'h00;
        end else begin
          q_job.bytes[5] = in_value;
        end
        q_job.nbytes  = JOB_IDX_W'(6);
        q_job.restart = 1'b1;
        q_job.close   = 1'b1;
      end
      CMD_HEADER: begin
        q_job.bytes[2] = in_register_address[15:8];
        q_job.bytes[3] = in_register_address[7:0];
        q_job.bytes[5] = in_count;
        q_job.bytes[6] = byte_cnt;
        q_job.nbytes   = JOB_IDX_W'(7);
        q_job.restart  = 1'b1;
        coil_mode_nxt  = (in_function_code == FC_WRITE_COILS);
      end
      CMD_PAYLOAD: begin
        if (coil_mode_r) begin
          q_job.bytes[0] = in_value;
          q_job.nbytes   = JOB_IDX_W'(1);
        end else begin
          q_job.bytes[0] = 8'h00;
          q_job.bytes[1] = in_value;
          q_job.nbytes   = JOB_IDX_W'(2);
        end
        q_job.close = in_last_item;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coil_mode_r <= 1'b0;
    end else if (q_push) begin
      coil_mode_r <= coil_mode_nxt;
    end
  end

endmodule

FILE: rtl/mbrf_jobq.sv
// Short job queue between the front end and the serialiser.
module mbrf_jobq
  import mbrf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t job_in,
  output logic full,
  input  logic pop,
  output job_t job_out,
  output logic empty
);

  job_t               mem_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wr_ptr_r;
  logic [JOBQ_AW-1:0] rd_ptr_r;
  logic [JOBQ_CW-1:0] count_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == JOBQ_CW'(JOBQ_DEPTH));
  assign empty   = (count_r == '0);
  assign job_out = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + JOBQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + JOBQ_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + JOBQ_CW'(1);
        2'b01:   count_r <= count_r - JOBQ_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/mbrf_back.sv
// Back end: serialises job bytes, runs the CRC and buffers outgoing beats.
module mbrf_back
  import mbrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_frame_byte,
  output logic       out_end_of_frame
);

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_CRCL = 2'd1;
  localparam logic [1:0] PH_CRCH = 2'd2;

  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       eof;
  } beat_t;

  job_t                 cur_r, cur_nxt;
  logic                 valid_r, valid_nxt;
  logic [JOB_IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [15:0]          crc_r, crc_nxt;
  logic                 emit;
  logic                 finish;
  beat_t                beat;

  beat_t                oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0]     oq_wr_r;
  logic [OQ_AW-1:0]     oq_rd_r;
  logic [OQ_CW-1:0]     oq_cnt_r;
  logic                 oq_full;
  logic                 oq_pop;

  assign oq_full          = (oq_cnt_r == OQ_CW'(OQ_DEPTH));
  assign out_empty        = (oq_cnt_r == '0);
  assign oq_pop           = out_pop && !out_empty;
  assign out_frame_byte   = oq_r[oq_rd_r].frame_byte;
  assign out_end_of_frame = oq_r[oq_rd_r].eof;

  always_comb begin
    emit      = valid_r && !oq_full;
    finish    = 1'b0;
    cur_nxt   = cur_r;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    beat      = '0;
    case (phase_r)
      PH_DATA: beat.frame_byte = cur_r.bytes[idx_r];
      PH_CRCL: beat.frame_byte = crc_r[7:0];
      PH_CRCH: begin
        beat.frame_byte = crc_r[15:8];
        beat.eof        = 1'b1;
      end
      default: ;
    endcase
    if (emit) begin
      case (phase_r)
        PH_DATA: begin
          crc_nxt = crc_byte(crc_r, cur_r.bytes[idx_r]);
          if (idx_r == cur_r.nbytes - JOB_IDX_W'(1)) begin
            if (cur_r.close) begin
              phase_nxt = PH_CRCL;
            end else begin
              finish = 1'b1;
            end
          end else begin
            idx_nxt = idx_r + JOB_IDX_W'(1);
          end
        end
        PH_CRCL: phase_nxt = PH_CRCH;
        PH_CRCH: begin
          crc_nxt = CRC_INIT;
          finish  = 1'b1;
        end
        default: ;
      endcase
    end
    if (finish) begin
      valid_nxt = 1'b0;
    end
    q_pop = (!valid_r || finish) && !q_empty;
    if (q_pop) begin
      cur_nxt   = q_job;
      valid_nxt = 1'b1;
      idx_nxt   = '0;
      phase_nxt = PH_DATA;
      if (q_job.restart) begin
        crc_nxt = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
      phase_r <= PH_DATA;
      crc_r   <= CRC_INIT;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_r[oq_wr_r] <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (emit) begin
        oq_wr_r <= oq_wr_r + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + OQ_AW'(1);
      end
      case ({emit, oq_pop})
        2'b10:   oq_cnt_r <= oq_cnt_r + OQ_CW'(1);
        2'b01:   oq_cnt_r <= oq_cnt_r - OQ_CW'(1);
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

  a_crc_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && phase_r == PH_CRCH) |=> (crc_r == CRC_INIT))
    else $error("CRC not reinitialised after frame close");

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && phase_r == PH_DATA) |-> (idx_r < cur_r.nbytes))
    else $error("byte index beyond job length");

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= OQ_CW'(OQ_DEPTH))
    else $error("output queue overfilled");

  a_eof_from_crch: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && beat.eof) |-> (phase_r == PH_CRCH && cur_r.close))
    else $error("end of frame outside a closing job");

endmodule

FILE: rtl/modbus_rtu_request_framer_top.sv
// Top level of the Modbus RTU request framer.
// Input channel: drive in_* fields with in_push; a beat is taken on a clock
// edge where in_push is high and in_full is low. Commands: read request,
// write single, write-multiple header and payload element.
// Result channel: while out_empty is low, out_frame_byte is the oldest frame
// byte waiting; pop it with out_pop. out_end_of_frame marks the CRC high byte.
// Path: an item is written into the job queue, then loaded into the serialiser's
// job register, and each frame byte is registered into the output queue.
// Throughput: one frame byte per cycle while the output queue has room, set
// by the single byte-wide CRC update in the serialiser; an item has 1 to 8
// frame bytes (8 for a read or write-single frame, 7 for a header, 1 to 4
// for a payload element).
// A two-entry job queue parts the front end from the serialiser, and a
// two-entry output queue parts the serialiser from the receiver. When the
// receiver stalls, the output queue fills, the serialiser holds, the job
// queue fills and in_full rises; nothing is dropped.
// Reset (rst_n low, synchronous) empties both queues, sets the CRC to FFFF
// and selects register payload mode.
module modbus_rtu_request_framer_top
  import mbrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_slave_address,
  input  logic [7:0]  in_function_code,
  input  logic [15:0] in_register_address,
  input  logic [7:0]  in_count,
  input  logic [7:0]  in_value,
  input  logic        in_last_item,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_frame_byte,
  output logic        out_end_of_frame
);

  job_t f_job;
  job_t q_job;
  logic f_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  mbrf_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_cmd              (in_cmd),
    .in_slave_address    (in_slave_address),
    .in_function_code    (in_function_code),
    .in_register_address (in_register_address),
    .in_count            (in_count),
    .in_value            (in_value),
    .in_last_item        (in_last_item),
    .q_full              (q_full),
    .q_push              (f_push),
    .q_job               (f_job)
  );

  mbrf_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .job_in  (f_job),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (q_job),
    .empty   (q_empty)
  );

  mbrf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_job            (q_job),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_frame_byte   (out_frame_byte),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule
